### design/mer_pkg.sv
`default_nettype none

package mer_pkg;

  localparam int DEC_W    = 40;
  localparam int OUT_W    = 10;
  localparam int CORNER_W = 8;

  typedef enum logic [18:0] {
    ST_IDLE = 19'h00001,
    ST_SA   = 19'h00002,
    ST_SB   = 19'h00004,
    ST_SC   = 19'h00008,
    ST_SD   = 19'h00010,
    ST_STA  = 19'h00020,
    ST_STB  = 19'h00040,
    ST_STC  = 19'h00080,
    ST_SETA = 19'h00100,
    ST_SETB = 19'h00200,
    ST_SETC = 19'h00400,
    ST_RIA  = 19'h00800,
    ST_RIB  = 19'h01000,
    ST_RIC  = 19'h02000,
    ST_RID  = 19'h04000,
    ST_RIE  = 19'h08000,
    ST_RIF  = 19'h10000,
    ST_ENDC = 19'h20000,
    ST_EMIT = 19'h40000
  } mer_state_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } mer_kind_e;

endpackage

`default_nettype wire

### design/mer_mul.sv
`default_nettype none

module mer_mul #(
  parameter int W = 19
) (
  input  logic                             clk_i,
  input  logic signed [W-1:0]              a_i,
  input  logic signed [W-1:0]              b_i,
  output logic signed [mer_pkg::DEC_W-1:0] p_o
);
  import mer_pkg::*;

  logic signed [2*W-1:0]   prod_full;
  logic signed [DEC_W-1:0] p_q;

  assign prod_full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= DEC_W'(prod_full);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### design/midpoint_ellipse_rasterizer.sv
`default_nettype none
// Channel  Direction  tdata                                   tuser      tlast
// s_axis   in         corners x1[7:0] y1[15:8] x2[23:16]      kind       -
//                     y2[31:24]
// m_axis   out        x_right[9:0] x_left[19:10]              valid_res  last
//                     y_lower[29:20] y_upper[39:30]
// Every decision product goes through the one registered multiplier of
// 2*COORD_BITS+3 bit operands in turn; a step request with no ellipse in
// progress goes straight to the emit state.
// Reset clears the sequencer, the drawing flags and the output valid.
// A result waiting on m_axis holds the sequencer only in its last state.

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [31:0]             s_axis_tdata,   // x1, y1, x2, y2
  input  logic                    s_axis_tuser,   // kind
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata,   // x_right, x_left, y_lower, y_upper
  output logic                    m_axis_tuser,   // valid_res
  output logic                    m_axis_tlast    // last
);
  import mer_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int MW    = 2 * COORD_BITS + 3;
  localparam int EXT_W = (COORD_BITS + 2 > OUT_W) ? COORD_BITS + 2 : OUT_W;

  mer_state_e state_q, state_d;

  logic [CB-1:0]        cx_q, cy_q, ox_q;
  logic [CB-2:0]        a_q, b_q, oy_q;
  logic [2*CB-3:0]      a2_q, b2_q;
  logic signed [DEC_W-1:0] dec_q, t_q, prod;
  logic                 region_q, active_q, pos_q, zero_q;
  logic                 m_valid_q;
  logic [OUT_W-1:0]     xr_q, xl_q, yl_q, yu_q;
  logic                 res_valid_q, last_q;

  logic                 in_acc, kind_step;
  logic [CB-1:0]        x1, y1, x2, y2, dx, dy;
  logic [CB:0]          sx, sy;

  logic signed [MW-1:0] a_s, b_s, x_s, y_s, a2_s, b2_s, t_s;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [DEC_W-1:0] step_term;
  logic                 emit_go;

  logic [EXT_W-1:0]     cx_e, cy_e, ox_e, oy_e;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind_step     = (s_axis_tuser == KIND_STEP);

  assign x1 = CB'(s_axis_tdata[7:0]);
  assign y1 = CB'(s_axis_tdata[15:8]);
  assign x2 = CB'(s_axis_tdata[23:16]);
  assign y2 = CB'(s_axis_tdata[31:24]);
  assign sx = {1'b0, x1} + {1'b0, x2};
  assign sy = {1'b0, y1} + {1'b0, y2};
  assign dx = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
  assign dy = (y2 >= y1) ? (y2 - y1) : (y1 - y2);

  assign a_s  = signed'(MW'(a_q));
  assign b_s  = signed'(MW'(b_q));
  assign x_s  = signed'(MW'(ox_q));
  assign y_s  = signed'(MW'(oy_q));
  assign a2_s = signed'(MW'(a2_q));
  assign b2_s = signed'(MW'(b2_q));
  assign t_s  = t_q[MW-1:0];

  assign step_term = region_q ? (prod <<< 4) : (prod <<< 2);
  assign emit_go   = !m_valid_q || m_axis_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SA:   begin mul_a = a_s;  mul_b = a_s; end
      ST_SB:   begin mul_a = b_s;  mul_b = b_s; end
      ST_SC:   begin mul_a = a2_s; mul_b = MW'(1) - (b_s <<< 2); end
      ST_STA:  begin
        mul_a = b2_s;
        mul_b = (x_s <<< 1) + (region_q ? MW'(2) : MW'(3));
      end
      ST_STB:  begin
        mul_a = a2_s;
        mul_b = (region_q ? MW'(3) : MW'(2)) - (y_s <<< 1);
      end
      ST_SETA: begin mul_a = b2_s; mul_b = x_s + MW'(1); end
      ST_SETB: begin mul_a = a2_s; mul_b = (y_s <<< 1) - MW'(1); end
      ST_RIA:  begin mul_a = (x_s <<< 1) + MW'(1); mul_b = (x_s <<< 1) + MW'(1); end
      ST_RIB:  begin mul_a = y_s - MW'(1); mul_b = y_s - MW'(1); end
      ST_RIC:  begin mul_a = b2_s; mul_b = t_s; end
      ST_RID:  begin mul_a = a2_s; mul_b = t_s; end
      ST_RIE:  begin mul_a = a2_s; mul_b = b2_s; end
      ST_IDLE, ST_SD, ST_STC, ST_SETC, ST_RIF, ST_ENDC, ST_EMIT: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mer_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!kind_step)    state_d = ST_SA;
          else if (active_q) state_d = ST_STA;
          else               state_d = ST_EMIT;
        end
      end
      ST_SA:   state_d = ST_SB;
      ST_SB:   state_d = ST_SC;
      ST_SC:   state_d = ST_SD;
      ST_SD:   state_d = ST_SETA;
      ST_STA:  state_d = ST_STB;
      ST_STB:  state_d = ST_STC;
      ST_STC:  state_d = ST_SETA;
      ST_SETA: state_d = region_q ? ST_ENDC : ST_SETB;
      ST_SETB: state_d = ST_SETC;
      ST_SETC: state_d = (t_q < prod) ? ST_EMIT : ST_RIA;
      ST_RIA:  state_d = ST_RIB;
      ST_RIB:  state_d = ST_RIC;
      ST_RIC:  state_d = ST_RID;
      ST_RID:  state_d = ST_RIE;
      ST_RIE:  state_d = ST_RIF;
      ST_RIF:  state_d = ST_ENDC;
      ST_ENDC: state_d = ST_EMIT;
      ST_EMIT: if (emit_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= 1'b0;
      region_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_acc && !kind_step) begin
        active_q <= 1'b1;
        region_q <= 1'b0;
      end
      if (state_q == ST_SETC && !(t_q < prod)) region_q <= 1'b1;
      if (state_q == ST_ENDC && oy_q == '0) active_q <= 1'b0;
      if (state_q == ST_EMIT && emit_go) m_valid_q <= 1'b1;
      else if (m_axis_tready)            m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          zero_q <= kind_step && !active_q;
          if (!kind_step) begin
            cx_q <= sx[CB:1];
            cy_q <= sy[CB:1];
            a_q  <= dx[CB-1:1];
            b_q  <= dy[CB-1:1];
            ox_q <= '0;
            oy_q <= dy[CB-1:1];
          end
        end
      end
      ST_SB:   a2_q  <= prod[2*CB-3:0];
      ST_SC:   b2_q  <= prod[2*CB-3:0];
      ST_SD:   dec_q <= prod + (DEC_W'(b2_q) <<< 2);
      ST_STA:  pos_q <= (dec_q > 0);
      ST_STB:  if (!region_q || !pos_q) dec_q <= dec_q + step_term;
      ST_STC: begin
        if (region_q || pos_q) dec_q <= dec_q + step_term;
        if (!region_q || !pos_q) ox_q <= ox_q + 1'b1;
        if (region_q || pos_q)   oy_q <= oy_q - 1'b1;
      end
      ST_SETB: t_q   <= prod <<< 1;
      ST_RIB:  t_q   <= prod;
      ST_RIC:  t_q   <= prod;
      ST_RID:  dec_q <= prod <<< 2;
      ST_RIE:  dec_q <= dec_q + (prod <<< 4);
      ST_RIF:  dec_q <= dec_q - (prod <<< 4);
      ST_EMIT: begin
        if (emit_go) begin
          res_valid_q <= !zero_q;
          last_q      <= !zero_q && !active_q;
          xr_q <= zero_q ? '0 : OUT_W'(cx_e + ox_e);
          xl_q <= zero_q ? '0 : OUT_W'(cx_e - ox_e);
          yl_q <= zero_q ? '0 : OUT_W'(cy_e + oy_e);
          yu_q <= zero_q ? '0 : OUT_W'(cy_e - oy_e);
        end
      end
      default: ;
    endcase
  end

  assign cx_e = EXT_W'(cx_q);
  assign cy_e = EXT_W'(cy_q);
  assign ox_e = EXT_W'(ox_q);
  assign oy_e = EXT_W'(oy_q);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {yu_q, yl_q, xl_q, xr_q};
  assign m_axis_tuser  = res_valid_q;
  assign m_axis_tlast  = last_q;

  a_idle_step_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_step && !active_q |=> state_q == ST_EMIT)
    else $error("step without ellipse did not go straight to emit");

  a_region_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_q && !(in_acc && !kind_step) |=> region_q)
    else $error("second region left without a start request");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("empty result carries coordinates or last");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !kind_step |=> active_q && !region_q)
    else $error("start request did not arm the drawing");

endmodule

`default_nettype wire
